// ===== rtl/huffman_code_bit_packer_macros.svh =====
// Assertion macros shared by the Huffman code bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define HCBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define HCBP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HCBP_ASSERT(lbl, clk, rst, prop, msg)
`define HCBP_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/hcbp_pkg.sv =====
// Package with the opcodes and field widths of the Huffman code bit packer.
package hcbp_pkg;

  // Opcodes carried in the input tuser.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // Field widths.
  localparam int OP_W      = 2;
  localparam int SYMBOL_W  = 8;
  localparam int LEN_W     = 6;
  localparam int CODE_W    = 32;
  localparam int BYTE_BITS = 8;

  // Input tdata: symbol, code_len, code_value, padded to whole bytes.
  localparam int IN_BITS  = SYMBOL_W + LEN_W + CODE_W;
  localparam int TDATA_W  = ((IN_BITS + 7) / 8) * 8;

endpackage

// ===== rtl/huffman_code_bit_packer.sv =====
// Table-driven Huffman encoder that packs codes MSB-first into output bytes.
//
// Input channel s_*: tuser carries the opcode (load, encode, flush); tdata
// carries the symbol, the code length and the code bits. A load beat writes
// one code table entry and marks it valid. An encode beat reads the entry of
// its symbol from the table memory (one registered read) and then a shared
// shift unit moves up to eight code bits per cycle into the byte accumulator,
// except while a full byte waits for the output register. A flush beat pads
// a partial byte with zeros and sends it. Output channel m_*: tdata is one
// packed byte, tlast marks the final byte that an input beat produces.
// A load, an unused opcode, an empty flush or an encode of an unloaded
// symbol ends in the idle state; a flush with pending bits passes the flush
// state; an encode of a loaded symbol passes the lookup state and, for a
// nonzero length, ceil((pending + length) / 8) shift steps, at most 5 for a
// 32-bit code; the shift unit and the single table read port set the steps.
// s_tready is high only while the sequencer is idle, so one item is in work
// at a time. A finished byte waits in the output register; when m_tready is
// low the step that would complete the next byte waits for it.
// Reset clears all table valid marks at once and empties the accumulator;
// table contents are not cleared.
module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input beat.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [hcbp_pkg::TDATA_W-1:0] s_tdata,  // symbol[7:0], code_len[13:8],
                                                 // code_value[45:14], zero pad
  input  logic [hcbp_pkg::OP_W-1:0]   s_tuser,   // op[1:0]
  // Output beat.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // out_byte[7:0]
  output logic                        m_tlast    // last
);

  import hcbp_pkg::*;

`include "huffman_code_bit_packer_macros.svh"

  localparam int IW = $clog2(SYMBOL_COUNT);
  localparam int W  = MAX_CODE_BITS;
  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int EW = LW + W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0]             state;
  logic [SYMBOL_COUNT-1:0] valid;
  logic [EW-1:0]          table_mem [SYMBOL_COUNT];
  logic [EW-1:0]          rd_q;
  logic [W-1:0]           code_reg;
  logic [LW-1:0]          rem;
  logic [7:0]             pending;
  logic [2:0]             pc;

  // Unpacked input fields.
  logic [SYMBOL_W-1:0]    in_sym;
  logic [LEN_W-1:0]       in_len;
  logic [CODE_W-1:0]      in_code;
  logic [IW-1:0]          idx;
  logic                   in_range;
  logic                   accept;
  logic [LW-1:0]          len_cl;
  logic [W-1:0]           code_aligned;

  assign in_sym   = s_tdata[7:0];
  assign in_len   = s_tdata[13:8];
  assign in_code  = s_tdata[45:14];
  assign idx      = in_sym[IW-1:0];
  assign in_range = {1'b0, in_sym} < 9'(SYMBOL_COUNT);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Clamp the length and left-align the code so the first bit is the top bit.
  assign len_cl = (in_len > LEN_W'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS) : LW'(in_len);
  assign code_aligned = W'(in_code[W-1:0] << (LW'(MAX_CODE_BITS) - len_cl));

  // Shared shift unit: take as many bits as fit in the accumulator.
  logic       slot_free;
  logic [3:0] space;
  logic [3:0] take;
  logic [7:0] window;
  logic [7:0] taken;
  logic [3:0] fill;
  logic       full;
  logic [7:0] pending_next;
  logic [LW-1:0] rem_next;
  logic       out_load;

  assign slot_free    = !m_tvalid || m_tready;
  assign space        = 4'd8 - {1'b0, pc};
  assign take         = (rem < LW'(space)) ? 4'(rem) : space;
  assign window       = code_reg[W-1 -: 8];
  assign taken        = window >> (4'd8 - take);
  assign fill         = {1'b0, pc} + take;
  assign full         = (fill == 4'd8);
  assign pending_next = 8'(pending << take) | taken;
  assign rem_next     = rem - LW'(take);

  // A new byte enters the output register this cycle.
  assign out_load = slot_free && ((state == ST_SHIFT && full) || state == ST_FLUSH);

  // Code table memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && s_tuser == OP_LOAD && in_range) begin
      table_mem[idx] <= {len_cl, code_aligned};
    end
    rd_q <= table_mem[idx];
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      pending  <= '0;
      pc       <= '0;
      rem      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              OP_LOAD: begin
                if (in_range) begin
                  valid[idx] <= 1'b1;
                end
              end
              OP_ENCODE: begin
                if (in_range && valid[idx]) begin
                  state <= ST_LOOKUP;
                end
              end
              OP_FLUSH: begin
                if (pc != 3'd0) begin
                  state <= ST_FLUSH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOOKUP: begin
          code_reg <= rd_q[W-1:0];
          rem      <= rd_q[EW-1:W];
          state    <= (rd_q[EW-1:W] == '0) ? ST_IDLE : ST_SHIFT;
        end
        ST_SHIFT: begin
          if (!full || slot_free) begin
            code_reg <= code_reg << take;
            rem      <= rem_next;
            if (full) begin
              m_tdata  <= pending_next;
              m_tlast  <= (rem_next < LW'(8));
              pending  <= '0;
              pc       <= '0;
            end else begin
              pending  <= pending_next;
              pc       <= fill[2:0];
            end
            if (rem_next == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            m_tdata  <= 8'(pending << (4'd8 - {1'b0, pc}));
            m_tlast  <= 1'b1;
            pending  <= '0;
            pc       <= '0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The shift unit never runs with no bits left to move.
  `HCBP_ASSERT_NEVER(a_shift_nonempty, clk, rst, state == ST_SHIFT && rem == '0, "shift with no bits")
  // A flush is only in work when there is a partial byte to send.
  `HCBP_ASSERT_NEVER(a_flush_pending, clk, rst, state == ST_FLUSH && pc == 3'd0, "empty flush in work")
  // The remaining bit count never exceeds the longest code.
  `HCBP_ASSERT(a_rem_bound, clk, rst, rem <= LW'(MAX_CODE_BITS), "remaining bits out of range")
  // A completed byte is only written when the output register can take it.
  `HCBP_ASSERT(a_no_overwrite, clk, rst, (state == ST_SHIFT && full && m_tvalid && !m_tready) |=> $stable(m_tdata), "output byte overwritten")

endmodule

// ===== tb/huffman_code_bit_packer_tb.sv =====
// Self-checking testbench for the table-driven Huffman code bit packer.
module huffman_code_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  // The fourth opcode value has no function in the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = 256;
  localparam int CODE_BITS_MAX = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_DIRECTED = 25;

  // One directed beat; exp_bytes holds the first byte in its top bits.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sym;
    logic [5:0]  len;
    logic [31:0] code;
    bit          typed;
    logic [2:0]  n_bytes;
    logic [31:0] exp_bytes;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;  // symbol, code_len, code_value, zero pad
  logic [OP_W-1:0] s_tuser = '0;     // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;               // out_byte
  logic m_tlast;                     // last

  huffman_code_bit_packer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Directed beats: extremes and special cases first, then mixed traffic.
  dir_row_t directed_rows [N_DIRECTED] = '{
    // Encode of a symbol that has never been loaded.
    '{OP_ENCODE, 8'h00, 6'd0,  32'h0,        1'b1, 3'd0, 32'h0},
    // Flush with nothing pending.
    '{OP_FLUSH,  8'h00, 6'd0,  32'h0,        1'b1, 3'd0, 32'h0},
    // Unused opcode with every field bit set.
    '{OP_UNUSED, 8'hFF, 6'd63, 32'hFFFFFFFF, 1'b1, 3'd0, 32'h0},
    '{OP_LOAD,   8'h00, 6'd8,  32'h000000A5, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h00, 6'd0,  32'h0,        1'b1, 3'd1, 32'hA5000000},
    // Longest code, all ones.
    '{OP_LOAD,   8'hFF, 6'd32, 32'hFFFFFFFF, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'hFF, 6'd0,  32'h0,        1'b1, 3'd4, 32'hFFFFFFFF},
    // Zero-length code.
    '{OP_LOAD,   8'h01, 6'd0,  32'hFFFFFFFF, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h01, 6'd0,  32'h0,        1'b1, 3'd0, 32'h0},
    // Overlong lengths are held at the longest code.
    '{OP_LOAD,   8'h02, 6'd63, 32'h12345678, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h02, 6'd0,  32'h0,        1'b1, 3'd4, 32'h12345678},
    '{OP_LOAD,   8'h80, 6'd33, 32'h00000000, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h80, 6'd0,  32'h0,        1'b1, 3'd4, 32'h00000000},
    // Code bits above the length are dropped.
    '{OP_LOAD,   8'h03, 6'd3,  32'hFFFFFFFD, 1'b1, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h03, 6'd0,  32'h0,        1'b1, 3'd0, 32'h0},
    '{OP_FLUSH,  8'h00, 6'd0,  32'h0,        1'b1, 3'd1, 32'hA0000000},
    // Partial byte carried across a long code.
    '{OP_ENCODE, 8'h03, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    '{OP_ENCODE, 8'hFF, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    '{OP_FLUSH,  8'h00, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    // Overwrite of an entry already loaded.
    '{OP_LOAD,   8'h00, 6'd7,  32'h00000055, 1'b0, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h00, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h00, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    '{OP_LOAD,   8'h7F, 6'd13, 32'hAAAAAAAA, 1'b0, 3'd0, 32'h0},
    '{OP_ENCODE, 8'h7F, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0},
    '{OP_FLUSH,  8'h00, 6'd0,  32'h0,        1'b0, 3'd0, 32'h0}
  };

  // Shadow of the code table and the byte accumulator.
  bit          code_valid [TABLE_DEPTH];
  logic [5:0]  code_length [TABLE_DEPTH];
  logic [31:0] code_bits [TABLE_DEPTH];
  logic [7:0]  acc_bits = '0;
  int unsigned acc_count = 0;

  packed_byte_t pending_bytes [$];
  logic [7:0] loaded_symbols [$];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Updates the shadow state for one beat and returns the bytes it sends.
  function automatic int pack_codes(input logic [1:0] op, input logic [7:0] sym,
                                    input logic [5:0] len, input logic [31:0] code,
                                    output logic [31:0] bytes);
    int n;
    logic [5:0] stored_len;
    logic [63:0] mask;
    n = 0;
    bytes = '0;
    case (op)
      OP_LOAD: begin
        stored_len = (len > CODE_BITS_MAX) ? 6'(CODE_BITS_MAX) : len;
        mask = (64'd1 << stored_len) - 64'd1;
        code_length[sym] = stored_len;
        code_bits[sym] = code & mask[31:0];
        code_valid[sym] = 1'b1;
      end
      OP_ENCODE: begin
        if (code_valid[sym]) begin
          for (int i = code_length[sym]; i > 0; i--) begin
            acc_bits = {acc_bits[6:0], code_bits[sym][i-1]};
            acc_count++;
            if (acc_count == BYTE_BITS) begin
              bytes[31-8*n -: 8] = acc_bits;
              n++;
              acc_bits = '0;
              acc_count = 0;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (acc_count > 0) begin
          bytes[31:24] = acc_bits << (BYTE_BITS - acc_count);
          n = 1;
          acc_bits = '0;
          acc_count = 0;
        end
      end
      default: begin
      end
    endcase
    return n;
  endfunction

  function automatic void report_mismatch(input string what, input int exp_val,
                                          input int act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch at %0t: %s expected %0h actual %0h", $realtime, what,
               exp_val, act_val);
  endfunction

  // Drives one beat, starting and ending at a falling edge. Valid is left
  // high so that a following beat may go out back to back.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] sym,
                           input logic [5:0] len, input logic [31:0] code,
                           input bit typed, input int n_typed,
                           input logic [31:0] typed_bytes);
    logic [TDATA_W-1:0] data;
    logic [31:0] bytes;
    int n;
    packed_byte_t entry;
    data = '0;
    data[IN_BITS-1:0] = {code, len, sym};
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = pack_codes(op, sym, len, code, bytes);
    if (typed) begin
      n = n_typed;
      bytes = typed_bytes;
    end
    for (int k = 0; k < n; k++) begin
      entry.data = bytes[31-8*k -: 8];
      entry.last = (k == n - 1);
      pending_bytes.insert(pending_bytes.size(), entry);
    end
    if (op == OP_LOAD)
      loaded_symbols.insert(loaded_symbols.size(), sym);
    @(negedge clk);
  endtask

  // Mostly loads and encodes of loaded symbols, with flushes and some noise.
  task automatic send_random(input int count);
    int pick;
    int len_pick;
    logic [1:0] op;
    logic [7:0] sym;
    logic [5:0] len;
    logic [31:0] code;
    repeat (count) begin
      pick = $urandom_range(99);
      sym = 8'($urandom_range(255));
      len = 6'($urandom_range(63));
      code = $urandom();
      if (pick < 25 || loaded_symbols.size() == 0) begin
        op = OP_LOAD;
        len_pick = $urandom_range(99);
        if (len_pick < 5)
          len = 6'd0;
        else if (len_pick < 12)
          len = 6'd32;
        else if (len_pick < 17)
          len = 6'($urandom_range(63, 33));
        else
          len = 6'($urandom_range(20, 1));
      end else if (pick < 85) begin
        op = OP_ENCODE;
        if ($urandom_range(9) != 0)
          sym = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
      end else if (pick < 96) begin
        op = OP_FLUSH;
      end else begin
        op = OP_UNUSED;
      end
      send_beat(op, sym, len, code, 1'b0, 0, '0);
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare every output beat with the oldest expected byte.
  always @(posedge clk) begin : check_output
    packed_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 0, m_tdata);
      end else begin
        want = pending_bytes.pop_front();
        if (m_tdata !== want.data)
          report_mismatch("out_byte", want.data, m_tdata);
        if (m_tlast !== want.last)
          report_mismatch("last", want.last, m_tlast);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL huffman_code_bit_packer");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles a little, receiver stalls a lot.
    src_idle_pct = 27;
    snk_idle_pct = 80;
    foreach (directed_rows[i])
      send_beat(directed_rows[i].op, directed_rows[i].sym, directed_rows[i].len,
                directed_rows[i].code, directed_rows[i].typed,
                directed_rows[i].n_bytes, directed_rows[i].exp_bytes);
    send_random(25);

    // Phase two: the other way round, with a full drain half way.
    src_idle_pct = 80;
    snk_idle_pct = 27;
    send_random(12);
    s_tvalid <= 1'b0;
    wait (pending_bytes.size() == 0);
    @(negedge clk);
    send_random(12);

    // Phase three: no idling on either side.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_random(26);
    s_tvalid <= 1'b0;

    wait (pending_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bytes.size() == 0)
      $display("PASS huffman_code_bit_packer");
    else
      $display("FAIL huffman_code_bit_packer");
    $finish;
  end

endmodule
